[design/mavle_pkg.sv]
`timescale 1ns / 1ps

package mavle_pkg;

  // Field widths fixed by the interface.
  localparam int DATA_W     = 16;
  localparam int WL_W       = 13;
  localparam int CFG_IDX_W  = 2;

  // Serial divider: the mean never exceeds 32768, so 16 quotient bits suffice.
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;

  // Multiplier chain widths: |audio| * mean fits in 31 bits, times level in 47.
  localparam int P1_W        = 31;
  localparam int P2_W        = 47;
  localparam int ROUND_SHIFT = 27;

  // Register reset values.
  localparam logic [DATA_W-1:0] LEVEL_RESET  = 16'd4096;
  localparam int                WINDOW_RESET = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL  = 2'd0,
    CFG_WINDOW = 2'd1
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SETUP,
    ST_DIVIDE,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic update;
    logic div_init;
    logic div_step;
    logic mul1;
    logic mul2;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

[design/moving_average_level_expander.sv]
// An accepted item goes through read, window update, a 16-step serial divide,
// two multiplies and the output load; no new item is taken until it is loaded.
// A waiting result sits in an output register while the next item is taken.
// Reset clears control state, the running sum, write position and fill count.
// The history RAM is not swept: slots read before the window fills count as zero.
`timescale 1ns / 1ps

module moving_average_level_expander #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mavle_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mavle_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mavle_pkg::DATA_W-1:0] detect_sample_i,
  input  logic signed [mavle_pkg::DATA_W-1:0] audio_sample_i,
  input  logic                                block_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mavle_pkg::DATA_W-1:0] scaled_sample_o,
  output logic                                block_end_res_o
);
  import mavle_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  mavle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Window, divider, multipliers and output register.
  mavle_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .detect_sample_i (detect_sample_i),
    .audio_sample_i  (audio_sample_i),
    .block_end_i     (block_end_i),
    .scaled_sample_o (scaled_sample_o),
    .block_end_res_o (block_end_res_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

`ifndef SYNTHESIS
  // Once an item is taken, no other is taken until it has been worked off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.update, cmd.div_init, cmd.div_step,
              cmd.mul1, cmd.mul2, cmd.load_out}))
    else $error("overlapping datapath commands");

  // The window update is always followed by the divider setup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |=> cmd.div_init)
    else $error("divider not seeded after window update");

  // A result appears only after the controller loads the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result valid without an output load");
`endif

endmodule

[design/mavle_ram.sv]
`timescale 1ns / 1ps

module mavle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/mavle_ctrl.sv]
`timescale 1ns / 1ps

module mavle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mavle_pkg::status_t status_i,
  output mavle_pkg::cmd_t    cmd_o
);
  import mavle_pkg::*;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // State register and divide step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_READ;
        end
      end
      // The window RAM reads the slot being replaced in this cycle.
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_LOAD;
      end
      // Wait here while the previous result still sits unclaimed.
      ST_LOAD: begin
        if (!status_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/mavle_dp.sv]
`timescale 1ns / 1ps

module mavle_dp #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mavle_pkg::cmd_t                        cmd_i,
  output mavle_pkg::status_t                     status_o,
  input  logic                                   cfg_we_i,
  input  logic [mavle_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mavle_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic signed [mavle_pkg::DATA_W-1:0]    detect_sample_i,
  input  logic signed [mavle_pkg::DATA_W-1:0]    audio_sample_i,
  input  logic                                   block_end_i,
  output logic signed [mavle_pkg::DATA_W-1:0]    scaled_sample_o,
  output logic                                   block_end_res_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i
);
  import mavle_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int SW   = CW + 15;
  localparam int CMPW = (CW > WL_W) ? CW : WL_W;
  localparam logic [CW-1:0] WIN_RESET =
    (WINDOW_RESET > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(WINDOW_RESET);

  // Configuration and window state.
  logic [DATA_W-1:0] level_q;
  logic [CW-1:0]     win_q;
  logic [AW-1:0]     pos_q;
  logic [CW-1:0]     fill_q;
  logic [SW-1:0]     sum_q;

  // Item payload.
  logic [DATA_W-1:0] det_mag_q;
  logic [DATA_W-1:0] aud_mag_q;
  logic              aud_neg_q;
  logic              blk_q;

  // Divider, multiplier and output registers.
  logic [CW-1:0]     rem_q;
  logic [DATA_W-1:0] dvd_q;
  logic [DATA_W-1:0] quot_q;
  logic [P1_W-1:0]   p1_q;
  logic [P2_W-1:0]   p2_q;
  logic [DATA_W-1:0] scaled_q;
  logic              blk_out_q;
  logic              out_valid_q;

  logic              level_we;
  logic              win_we;
  logic [CMPW-1:0]   wl_ext;
  logic [CW-1:0]     win_new;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] old_mag;
  logic [CW-1:0]     pos_inc;
  logic [CW:0]       trial;
  logic              trial_ge;
  logic [CW:0]       trial_sub;
  logic [31:0]       p1_full;
  logic [P2_W-1:0]   p2_full;
  logic [P2_W:0]     rnd_sum;
  logic [P2_W-ROUND_SHIFT:0] rnd;
  logic [DATA_W-1:0] sat_val;

  // Register write decode.
  always_comb begin
    level_we = 1'b0;
    win_we   = 1'b0;
    unique case (cfg_idx_e'(cfg_index_i))
      CFG_LEVEL:  level_we = cfg_we_i;
      CFG_WINDOW: win_we   = cfg_we_i;
      default: begin
        level_we = 1'b0;
        win_we   = 1'b0;
      end
    endcase
  end

  // A window length of zero means one; lengths above the RAM depth are clipped.
  assign wl_ext = CMPW'(cfg_data_i[WL_W-1:0]);
  always_comb begin
    if (wl_ext == '0) begin
      win_new = CW'(1);
    end else if (wl_ext > CMPW'(MAX_WINDOW)) begin
      win_new = CW'(MAX_WINDOW);
    end else begin
      win_new = CW'(wl_ext);
    end
  end

  // History RAM. Its contents are never cleared: a slot is only trusted once
  // the window has filled, because until then the write position equals the
  // fill count and the slot has not been written since the last clear.
  mavle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (pos_q),
    .wdata_i (det_mag_q),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  assign old_mag = (fill_q == win_q) ? ram_rdata : '0;
  assign pos_inc = CW'(pos_q) + CW'(1);

  // Configuration registers and window bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_RESET;
      win_q   <= WIN_RESET;
      pos_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      if (level_we) begin
        level_q <= cfg_data_i;
      end
      if (win_we) begin
        win_q  <= win_new;
        pos_q  <= '0;
        fill_q <= '0;
        sum_q  <= '0;
      end else if (cmd_i.update) begin
        sum_q <= sum_q - SW'(old_mag) + SW'(det_mag_q);
        pos_q <= (pos_inc >= win_q) ? '0 : pos_inc[AW-1:0];
        if (fill_q != win_q) begin
          fill_q <= fill_q + CW'(1);
        end
      end
    end
  end

  // Capture the item as magnitudes and a sign.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      det_mag_q <= detect_sample_i[DATA_W-1] ? DATA_W'(-detect_sample_i)
                                             : DATA_W'(detect_sample_i);
      aud_mag_q <= audio_sample_i[DATA_W-1] ? DATA_W'(-audio_sample_i)
                                            : DATA_W'(audio_sample_i);
      aud_neg_q <= audio_sample_i[DATA_W-1];
      blk_q     <= block_end_i;
    end
  end

  // Restoring divide of the sum by the fill count, one quotient bit a cycle.
  // The quotient fits in 16 bits, so the sum above bit 15 is already below
  // the divisor and seeds the partial remainder.
  assign trial     = {rem_q, dvd_q[DATA_W-1]};
  assign trial_ge  = trial >= {1'b0, fill_q};
  assign trial_sub = trial - {1'b0, fill_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= CW'(sum_q[SW-1:DATA_W]);
      dvd_q  <= sum_q[DATA_W-1:0];
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      dvd_q  <= {dvd_q[DATA_W-2:0], 1'b0};
      quot_q <= {quot_q[DATA_W-2:0], trial_ge};
    end
  end

  // Two registered multiplies: |audio| * mean, then times the gain.
  assign p1_full = aud_mag_q * quot_q;
  assign p2_full = p1_q * level_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q <= p1_full[P1_W-1:0];
    end
    if (cmd_i.mul2) begin
      p2_q <= p2_full;
    end
  end

  // Round half away from zero on the magnitude, then saturate by sign.
  assign rnd_sum = {1'b0, p2_q} + ((P2_W + 1)'(1) << (ROUND_SHIFT - 1));
  assign rnd     = rnd_sum[P2_W:ROUND_SHIFT];

  always_comb begin
    if (aud_neg_q) begin
      if (rnd > (P2_W - ROUND_SHIFT + 1)'(32768)) begin
        sat_val = 16'h8000;
      end else begin
        sat_val = DATA_W'(17'h10000 - rnd[DATA_W:0]);
      end
    end else begin
      if (rnd > (P2_W - ROUND_SHIFT + 1)'(32767)) begin
        sat_val = 16'h7fff;
      end else begin
        sat_val = rnd[DATA_W-1:0];
      end
    end
  end

  // Output register, freeing the core while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      scaled_q  <= sat_val;
      blk_out_q <= blk_q;
    end
  end

  assign status_o.out_full = out_valid_q & out_stall_i;
  assign scaled_sample_o   = scaled_q;
  assign block_end_res_o   = blk_out_q;
  assign out_valid_o       = out_valid_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mavle_pkg::*;

  localparam int HISTORY_DEPTH = 4096;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_ITEMS  = 460;
  localparam int WRAP_WINDOW   = 200;
  localparam int WRAP_ITEMS    = WRAP_WINDOW + 40;

  // Register indexes past the end of the list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] scaled;
    logic              block_end;
  } scaled_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    detect_sample_i;
  logic [DATA_W-1:0]    audio_sample_i;
  logic                 block_end_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DATA_W-1:0]    scaled_sample_o;
  logic                 block_end_res_o;

  // Predictor copy of the registers and the level window.
  logic [DATA_W-1:0] level_gain;
  logic [WL_W-1:0]   window_setting;
  logic [DATA_W-1:0] abs_history [HISTORY_DEPTH];
  longint unsigned   abs_sum;
  int unsigned       slot_next;
  int unsigned       fill_count;

  scaled_item_t pending_scaled [$];
  int           error_count = 0;
  bit           hold_request = 1'b0;

  moving_average_level_expander i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .detect_sample_i (detect_sample_i),
    .audio_sample_i  (audio_sample_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .scaled_sample_o (scaled_sample_o),
    .block_end_res_o (block_end_res_o)
  );

  always #2 clk_i = ~clk_i;

  // The window restarts empty after reset and after every window length write.
  task automatic clear_window();
    foreach (abs_history[i]) abs_history[i] = '0;
    abs_sum    = 0;
    slot_next  = 0;
    fill_count = 0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    if (idx == CFG_LEVEL) begin
      level_gain = data;
    end else if (idx == CFG_WINDOW) begin
      window_setting = data[WL_W-1:0];
      clear_window();
    end
  endtask

  // Update the window with one item and queue the scaled sample it must produce.
  task automatic predict_scaled(input logic [DATA_W-1:0] det, input logic [DATA_W-1:0] aud,
                                input logic mark);
    int unsigned     span;
    int unsigned     slot;
    int unsigned     det_mag;
    int unsigned     aud_mag;
    longint unsigned mean;
    longint unsigned product;
    longint unsigned rounded;
    scaled_item_t    item;
    span = window_setting;
    if (span == 0) span = 1;
    if (span > HISTORY_DEPTH) span = HISTORY_DEPTH;
    det_mag = det[DATA_W-1] ? 32'h10000 - det : det;
    aud_mag = aud[DATA_W-1] ? 32'h10000 - aud : aud;
    slot = slot_next;
    if (slot >= span) slot = 0;
    abs_sum = abs_sum - abs_history[slot] + det_mag;
    abs_history[slot] = det_mag[DATA_W-1:0];
    slot++;
    if (slot >= span) slot = 0;
    slot_next = slot;
    fill_count++;
    if (fill_count > span) fill_count = span;
    mean = (fill_count != 0) ? abs_sum / fill_count : 0;
    if (mean > 32768) mean = 32768;
    product = longint'(aud_mag) * mean * longint'(level_gain);
    rounded = (product + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    // Round half away from zero on the magnitude, then saturate per sign.
    if (aud[DATA_W-1]) begin
      if (rounded > 32768) rounded = 32768;
      item.scaled = DATA_W'(64'h10000 - rounded);
    end else begin
      if (rounded > 32767) rounded = 32767;
      item.scaled = DATA_W'(rounded);
    end
    item.block_end = mark;
    pending_scaled.push_back(item);
  endtask

  // Offer one item from the falling edge and hold it until the block takes it.
  task automatic send_item(input logic [DATA_W-1:0] det, input logic [DATA_W-1:0] aud,
                           input logic mark);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    detect_sample_i <= det;
    audio_sample_i  <= aud;
    block_end_i     <= mark;
    do @(posedge clk_i); while (in_stall_o);
    predict_scaled(det, aud, mark);
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Stop offering items and wait until every queued scaled sample has come back.
  task automatic wait_drained();
    pause_sender(1);
    while (pending_scaled.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_register(idx, data);
  endtask

  // Samples lean toward the extremes and toward small values near zero.
  function automatic logic [DATA_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: begin
        v = $urandom_range(0, 255);
        if ($urandom_range(0, 1) != 0) v = -v;
        return DATA_W'(v);
      end
      default: return DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return LEVEL_RESET;
      3: return DATA_W'($urandom_range(1, 64));
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // Mostly short windows so that they fill and wrap; unused upper bits are random.
  function automatic logic [DATA_W-1:0] pick_window();
    int unsigned span;
    case ($urandom_range(0, 9))
      0: span = 0;
      1: span = $urandom_range(17, 600);
      2: span = 1;
      default: span = $urandom_range(2, 16);
    endcase
    return {3'($urandom_range(0, 7)), WL_W'(span)};
  endfunction

  // Reset values: a zero detector first gives a zero mean and a zero output.
  task automatic test_reset_defaults();
    send_item(16'h0000, 16'h7fff, 1'b1);
    send_item(16'h8000, 16'h7fff, 1'b0);
    send_item(16'h7fff, 16'h8000, 1'b1);
    send_item(16'h0001, 16'hffff, 1'b0);
    wait_drained();
  endtask

  // A one-sample window makes the mean equal the current detector magnitude.
  task automatic test_rounding_saturation();
    write_register(CFG_WINDOW, 16'd1);
    write_register(CFG_LEVEL, 16'd64);
    // 1024 * 1024 * 64 sits exactly on the rounding midpoint.
    send_item(16'd1024, 16'd1024, 1'b0);
    send_item(16'd1024, -16'sd1024, 1'b1);
    send_item(-16'sd1024, 16'd1023, 1'b0);
    wait_drained();
    write_register(CFG_LEVEL, LEVEL_RESET);
    send_item(16'h8000, 16'h8000, 1'b1);
    send_item(16'h8000, 16'h7fff, 1'b0);
    wait_drained();
    write_register(CFG_LEVEL, 16'hffff);
    send_item(16'h8000, 16'h7fff, 1'b0);
    send_item(16'h8000, 16'h8000, 1'b1);
    send_item(16'd12345, -16'sd3, 1'b0);
    wait_drained();
    write_register(CFG_LEVEL, 16'h0000);
    send_item(16'h8000, 16'h7fff, 1'b1);
    wait_drained();
  endtask

  // Zero and oversized window lengths, and writes to indexes past the list.
  task automatic test_window_limits();
    write_register(CFG_LEVEL, LEVEL_RESET);
    write_register(CFG_WINDOW, 16'd0);
    send_item(16'd20000, 16'd30000, 1'b0);
    send_item(16'd100, 16'd30000, 1'b1);
    wait_drained();
    write_register(CFG_WINDOW, 16'hffff);
    send_item(16'h8000, 16'h7fff, 1'b0);
    send_item(16'h0000, 16'h7fff, 1'b1);
    send_item(16'h4000, 16'h8000, 1'b0);
    wait_drained();
    write_register(CFG_SPARE_A, 16'h0000);
    write_register(CFG_SPARE_B, 16'h0001);
    send_item(16'h7fff, 16'h7fff, 1'b1);
    send_item(16'h8001, 16'h8001, 1'b0);
    wait_drained();
  endtask

  // Phases of random traffic under random register settings.
  task automatic test_random_traffic();
    int sent;
    int phase_items;
    int burst_left;
    int gap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 2) != 0) write_register(CFG_LEVEL, pick_level());
      if ($urandom_range(0, 3) != 0) write_register(CFG_WINDOW, pick_window());
      if ($urandom_range(0, 7) == 0) begin
        write_register(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                       DATA_W'($urandom()));
      end
      phase_items = $urandom_range(20, 90);
      burst_left  = 0;
      repeat (phase_items) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          pause_sender(gap);
        end
        burst_left--;
        send_item(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
      end
      sent += phase_items;
    end
    wait_drained();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    write_register(CFG_WINDOW, 16'd5);
    write_register(CFG_LEVEL, pick_level());
    hold_request = 1'b1;
    repeat (30) send_item(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
    wait_drained();
    repeat (10) send_item(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // A long window, filled completely and wrapped around once.
  task automatic test_full_window_wrap();
    write_register(CFG_WINDOW, 16'(WRAP_WINDOW));
    write_register(CFG_LEVEL, LEVEL_RESET);
    repeat (WRAP_ITEMS) send_item(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    scaled_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_scaled.size() == 0) begin
        $display("%0t: unexpected result, expected none, got scaled_sample %0d",
                 $time, $signed(scaled_sample_o));
        error_count++;
      end else begin
        want = pending_scaled.pop_front();
        if (scaled_sample_o !== want.scaled) begin
          $display("%0t: scaled_sample expected %0d, got %0d", $time,
                   $signed(want.scaled), $signed(scaled_sample_o));
          error_count++;
        end
        if (block_end_res_o !== want.block_end) begin
          $display("%0t: block_end_res expected %0b, got %0b", $time,
                   want.block_end, block_end_res_o);
          error_count++;
        end
      end
    end
  end

  // Receiver stall pattern: stretches of different modes, plus a long hold on request.
  initial begin : receiver_pattern
    int   stretch_left;
    int   stall_mode;
    int   hold_left;
    logic stall_next;
    out_stall_i  = 1'b0;
    stretch_left = 0;
    stall_mode   = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 300);
        stall_mode   = $urandom_range(0, 3);
      end
      stretch_left--;
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = 1'($urandom_range(0, 1));
          2:       stall_next = ($urandom_range(0, 9) != 0);
          default: stall_next = stretch_left[3];
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // End the run when no item moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_LEVEL;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    detect_sample_i = '0;
    audio_sample_i  = '0;
    block_end_i     = 1'b0;
    clear_window();
    level_gain     = LEVEL_RESET;
    window_setting = WL_W'(WINDOW_RESET);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_rounding_saturation();
    test_window_limits();
    test_backpressure();
    test_random_traffic();
    test_full_window_wrap();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/mavle_pkg.sv
design/mavle_ram.sv
design/mavle_ctrl.sv
design/mavle_dp.sv
design/moving_average_level_expander.sv
bench/testbench.sv
